### design/rope_pkg.sv
// Shared constants, tables and types for the rotary position embedding block.
`timescale 1ns / 1ps

package rope_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_PAIRS_DEFAULT    = 64;
   localparam int SAMPLE_BITS_DEFAULT  = 16;
   localparam int CORDIC_STEPS_DEFAULT = 16;

   // Configuration register indexes
   localparam logic [2:0] CSR_START_POSITION     = 3'd0;
   localparam logic [2:0] CSR_PAIRS_IN_USE       = 3'd1;
   localparam logic [2:0] CSR_TOKENS_IN_SEQUENCE = 3'd2;
   localparam logic [2:0] CSR_FIRST_STEP         = 3'd3;
   localparam logic [2:0] CSR_STEP_RATIO         = 3'd4;
   localparam logic [2:0] CSR_INVERSE_MODE       = 3'd5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Configuration reset values
   localparam logic [19:0] START_POSITION_RESET     = 20'd0;
   localparam logic [6:0]  PAIRS_IN_USE_RESET       = 7'd64;
   localparam logic [15:0] TOKENS_IN_SEQUENCE_RESET = 16'd1;
   localparam logic [31:0] FIRST_STEP_RESET         = 32'd683565276;
   localparam logic [31:0] STEP_RATIO_RESET         = 32'd3719292214;

   // Field widths fixed by the register map
   localparam int POS_W   = 21;   // start position plus token count
   localparam int PHASE_W = 32;

   // CORDIC datapath: Q30 values with headroom for gain growth and negation
   localparam int CORDIC_W = 34;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   // Shared multiplier: 33x33 signed covers 32-bit unsigned and signed operands
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;

   // atan(2^-i) in 2^-32 turns
   localparam logic [31:0] ATAN_TURNS [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   // CORDIC status back to the sequencer
   typedef struct packed {
      logic                       busy;
      logic signed [CORDIC_W-1:0] cosine;
      logic signed [CORDIC_W-1:0] sine;
   } cordic_out_type;

endpackage

### design/rope_cordic.sv
// Iterative CORDIC rotator: one micro-rotation per cycle, phase in turns to cos/sin in Q30.
`timescale 1ns / 1ps

module rope_cordic import rope_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [PHASE_W-1:0]   phase,
   output cordic_out_type       result
);

   localparam logic [4:0] LAST_ITER = 5'(CORDIC_STEPS - 1);

   logic                       busy_ff, busy_in;
   logic [4:0]                 iter_ff, iter_in;
   logic                       flip_ff, flip_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in;
   logic signed [CORDIC_W-1:0] y_ff, y_in;
   logic signed [CORDIC_W-1:0] z_ff, z_in;

   logic [PHASE_W-1:0]         folded;
   logic                       fold;
   logic signed [CORDIC_W-1:0] dx, dy, da;

   // Fold the second and third quadrants by half a turn
   assign fold   = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
   assign folded = fold ? phase + 32'h80000000 : phase;

   // Shifted terms for this iteration
   assign dx = y_ff >>> iter_ff;
   assign dy = x_ff >>> iter_ff;
   assign da = CORDIC_W'(ATAN_TURNS[iter_ff]);

   always_comb begin
      busy_in = busy_ff;
      iter_in = iter_ff;
      flip_in = flip_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         flip_in = fold;
         x_in    = CORDIC_GAIN_Q30;
         y_in    = '0;
         z_in    = CORDIC_W'(signed'(folded));
      end else if (busy_ff) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - da;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + da;
         end
         iter_in = iter_ff + 5'd1;
         if (iter_ff == LAST_ITER) begin
            busy_in = 1'b0;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      flip_ff <= flip_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   // Undo the quadrant fold on the way out
   assign result.busy   = busy_ff;
   assign result.cosine = flip_ff ? -x_ff : x_ff;
   assign result.sine   = flip_ff ? -y_ff : y_ff;

endmodule

### design/rotary_position_embedding.sv
// Top level of the rotary position embedding pair rotator: sequencer, shared multiplier, CSRs.
`timescale 1ns / 1ps

// Rotates one feature pair per item by position times a per-pair frequency.
// An item is accepted only in idle; req_stall stays high while the sequencer is
// out of idle, so no new item is taken before the last one has been handed to
// the output register. The single 33x33 multiplier is used six times per item
// (phase, next frequency, four output products), and the CORDIC unit does one
// rotation per cycle. A finished result waits in the output register, and the
// next item is accepted while it waits.
// Configuration registers are written through csr_write_enable, csr_index and
// csr_wdata, and must only be written while no item is in flight.

module rotary_position_embedding import rope_pkg::*; #(
   parameter int MAX_PAIRS    = MAX_PAIRS_DEFAULT,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEFAULT,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration write port
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   // input items
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_first_value,
   input  logic signed [SAMPLE_BITS-1:0] req_second_value,
   // result items
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS:0]   rsp_rotated_first,
   output logic signed [SAMPLE_BITS:0]   rsp_rotated_second,
   output logic                          rsp_token_done
);

   localparam int PAIR_W  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int LIM_W   = (($clog2(MAX_PAIRS + 1) > 7) ? $clog2(MAX_PAIRS + 1) : 7) + 1;
   localparam int ACC_W   = PROD_W;
   localparam logic signed [ACC_W-1:0] SAT_HI =
      ACC_W'((65'(1) << SAMPLE_BITS) - 65'(1));
   localparam logic signed [ACC_W-1:0] SAT_LO  = -SAT_HI - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) <<< 29;

   // Sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_PHASE = 4'd1;
   localparam logic [3:0] ST_STEP  = 4'd2;
   localparam logic [3:0] ST_UPD   = 4'd3;
   localparam logic [3:0] ST_ROT   = 4'd4;
   localparam logic [3:0] ST_AC    = 4'd5;
   localparam logic [3:0] ST_BS    = 4'd6;
   localparam logic [3:0] ST_AS    = 4'd7;
   localparam logic [3:0] ST_BC    = 4'd8;
   localparam logic [3:0] ST_SUM   = 4'd9;
   localparam logic [3:0] ST_OUT   = 4'd10;

   // Configuration registers
   logic [19:0] start_position_ff;
   logic [6:0]  pairs_in_use_ff;
   logic [15:0] tokens_in_sequence_ff;
   logic [31:0] first_step_ff;
   logic [31:0] step_ratio_ff;
   logic        inverse_mode_ff;

   // Sequencer and state
   logic [3:0]        state_ff, state_in;
   logic [PAIR_W-1:0] pair_ff, pair_in;
   logic [15:0]       token_ff, token_in;
   logic [31:0]       running_ff, running_in;

   // Item registers
   logic signed [SAMPLE_BITS-1:0] a_ff, a_in;
   logic signed [SAMPLE_BITS-1:0] b_ff, b_in;
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic [31:0]                   step_ff, step_in;
   logic                          last_ff, last_in;
   logic                          tok_last_ff, tok_last_in;
   logic signed [MUL_W-1:0]       c_ff, c_in;
   logic signed [MUL_W-1:0]       s_ff, s_in;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0]       acc1_ff, acc1_in;
   logic signed [ACC_W-1:0]       acc2_ff, acc2_in;

   // Output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS:0]   rsp_first_ff, rsp_first_in;
   logic signed [SAMPLE_BITS:0]   rsp_second_ff, rsp_second_in;
   logic                          rsp_done_ff, rsp_done_in;

   logic                          accept;
   logic                          out_free;
   logic [LIM_W-1:0]              pairs_eff;
   logic [16:0]                   tokens_eff;
   logic signed [MUL_W-1:0]       mul_a, mul_b;
   logic                          cordic_start;
   logic signed [CORDIC_W-1:0]    sine_dir;
   cordic_out_type                cordic_out;

   // Round by half an LSB, drop 30 fraction bits, saturate to the output range
   function automatic logic signed [SAMPLE_BITS:0] finish(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] r;
      r = (acc + ROUND_C) >>> 30;
      if (r > SAT_HI) begin
         r = SAT_HI;
      end else if (r < SAT_LO) begin
         r = SAT_LO;
      end
      return r[SAMPLE_BITS:0];
   endfunction

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_position_ff     <= START_POSITION_RESET;
         pairs_in_use_ff       <= PAIRS_IN_USE_RESET;
         tokens_in_sequence_ff <= TOKENS_IN_SEQUENCE_RESET;
         first_step_ff         <= FIRST_STEP_RESET;
         step_ratio_ff         <= STEP_RATIO_RESET;
         inverse_mode_ff       <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_START_POSITION:     start_position_ff     <= csr_wdata[19:0];
            CSR_PAIRS_IN_USE:       pairs_in_use_ff       <= csr_wdata[6:0];
            CSR_TOKENS_IN_SEQUENCE: tokens_in_sequence_ff <= csr_wdata[15:0];
            CSR_FIRST_STEP:         first_step_ff         <= csr_wdata;
            CSR_STEP_RATIO:         step_ratio_ff         <= csr_wdata;
            CSR_INVERSE_MODE:       inverse_mode_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective limits: zero counts as one, pairs capped at MAX_PAIRS
   always_comb begin
      pairs_eff = LIM_W'(pairs_in_use_ff);
      if (pairs_eff == '0) begin
         pairs_eff = LIM_W'(1);
      end else if (pairs_eff > LIM_W'(MAX_PAIRS)) begin
         pairs_eff = LIM_W'(MAX_PAIRS);
      end
      tokens_eff = (tokens_in_sequence_ff == 16'd0) ? 17'd1 : 17'(tokens_in_sequence_ff);
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_PHASE: begin
            mul_a = MUL_W'(pos_ff);
            mul_b = MUL_W'(step_ff);
         end
         ST_STEP: begin
            mul_a = MUL_W'(step_ff);
            mul_b = MUL_W'(step_ratio_ff);
         end
         ST_AC: begin
            mul_a = MUL_W'(a_ff);
            mul_b = c_ff;
         end
         ST_BS: begin
            mul_a = MUL_W'(b_ff);
            mul_b = s_ff;
         end
         ST_AS: begin
            mul_a = MUL_W'(a_ff);
            mul_b = s_ff;
         end
         ST_BC: begin
            mul_a = MUL_W'(b_ff);
            mul_b = c_ff;
         end
         default: ;
      endcase
   end

   assign prod_in      = mul_a * mul_b;
   assign cordic_start = (state_ff == ST_STEP);
   assign sine_dir     = inverse_mode_ff ? -cordic_out.sine : cordic_out.sine;

   rope_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .phase  (prod_ff[PHASE_W-1:0]),
      .result (cordic_out)
   );

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      pair_in       = pair_ff;
      token_in      = token_ff;
      running_in    = running_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      last_in       = last_ff;
      tok_last_in   = tok_last_ff;
      c_in          = c_ff;
      s_in          = s_ff;
      acc1_in       = acc1_ff;
      acc2_in       = acc2_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_done_in   = rsp_done_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               a_in        = req_first_value;
               b_in        = req_second_value;
               pos_in      = POS_W'(start_position_ff) + POS_W'(token_ff);
               step_in     = (pair_ff == '0) ? first_step_ff : running_ff;
               last_in     = (LIM_W'(pair_ff) + LIM_W'(1)) >= pairs_eff;
               tok_last_in = (17'(token_ff) + 17'd1) >= tokens_eff;
               state_in    = ST_PHASE;
            end
         end
         ST_PHASE: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            state_in = ST_UPD;
         end
         // Advance pair and token counters while the CORDIC runs
         ST_UPD: begin
            if (last_ff) begin
               pair_in    = '0;
               running_in = first_step_ff;
               token_in   = tok_last_ff ? 16'd0 : token_ff + 16'd1;
            end else begin
               pair_in    = pair_ff + PAIR_W'(1);
               running_in = prod_ff[63:32];
            end
            state_in = ST_ROT;
         end
         ST_ROT: begin
            if (!cordic_out.busy) begin
               c_in     = cordic_out.cosine[MUL_W-1:0];
               s_in     = sine_dir[MUL_W-1:0];
               state_in = ST_AC;
            end
         end
         ST_AC: begin
            state_in = ST_BS;
         end
         ST_BS: begin
            acc1_in  = prod_ff;
            state_in = ST_AS;
         end
         ST_AS: begin
            acc1_in  = acc1_ff - prod_ff;
            state_in = ST_BC;
         end
         ST_BC: begin
            acc2_in  = prod_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            acc2_in  = acc2_ff + prod_ff;
            state_in = ST_OUT;
         end
         // Hand the result to the output register once it is free
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_first_in  = finish(acc1_ff);
               rsp_second_in = finish(acc2_ff);
               rsp_done_in   = last_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pair_ff      <= '0;
         token_ff     <= '0;
         running_ff   <= FIRST_STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pair_ff      <= pair_in;
         token_ff     <= token_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      pos_ff        <= pos_in;
      step_ff       <= step_in;
      last_ff       <= last_in;
      tok_last_ff   <= tok_last_in;
      c_ff          <= c_in;
      s_ff          <= s_in;
      prod_ff       <= prod_in;
      acc1_ff       <= acc1_in;
      acc2_ff       <= acc2_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rotated_first  = rsp_first_ff;
   assign rsp_rotated_second = rsp_second_ff;
   assign rsp_token_done     = rsp_done_ff;

endmodule

### tb/rotary_position_embedding_test.sv
// Self-checking testbench for the rotary position embedding pair rotator.
`timescale 1ns / 1ps

module rotary_position_embedding_test import rope_pkg::*; ;

   localparam int MAX_PAIRS    = MAX_PAIRS_DEFAULT;
   localparam int SAMPLE_BITS  = SAMPLE_BITS_DEFAULT;
   localparam int CORDIC_STEPS = CORDIC_STEPS_DEFAULT;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd6;

   localparam longint ROUND_HALF = 64'sd1 <<< 29;
   localparam longint SAMPLE_MAX = (64'sd1 <<< SAMPLE_BITS) - 1;
   localparam longint SAMPLE_MIN = -(64'sd1 <<< SAMPLE_BITS);

   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 2 * (CORDIC_STEPS + 10);
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic signed [SAMPLE_BITS:0] rotated_first;
      logic signed [SAMPLE_BITS:0] rotated_second;
      logic                        token_done;
   } rotated_pair_type;

   // DUT ports; the inputs are driven to known values from time zero
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_wdata = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_first_value = '0;
   logic signed [SAMPLE_BITS-1:0] req_second_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [SAMPLE_BITS:0]   rsp_rotated_first;
   logic signed [SAMPLE_BITS:0]   rsp_rotated_second;
   logic                          rsp_token_done;

   // Predictor copy of the registers and counters
   logic [19:0] cfg_start      = START_POSITION_RESET;
   logic [6:0]  cfg_pairs      = PAIRS_IN_USE_RESET;
   logic [15:0] cfg_tokens     = TOKENS_IN_SEQUENCE_RESET;
   logic [31:0] cfg_first_step = FIRST_STEP_RESET;
   logic [31:0] cfg_step_ratio = STEP_RATIO_RESET;
   logic        cfg_inverse    = 1'b0;
   int unsigned pair_index     = 0;
   int unsigned token_index    = 0;
   logic [31:0] freq_step      = FIRST_STEP_RESET;

   rotated_pair_type expected_rotations[$];
   int mismatch_count     = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_requests      = 0;
   logic hold_on          = 1'b0;

   rotary_position_embedding DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_value    (req_first_value),
      .req_second_value   (req_second_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_rotated_first  (rsp_rotated_first),
      .rsp_rotated_second (rsp_rotated_second),
      .rsp_token_done     (rsp_token_done)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Cosine and sine in Q30 from a phase in 2^-32 turns
   function automatic void cordic_sin_cos(input logic [31:0] phase, output longint cosine,
                                          output longint sine);
      logic        flip;
      logic [31:0] folded;
      longint      x, y, z, dx, dy, angle;
      // middle half of the circle: rotate by half a turn, negate at the end
      flip = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
      folded = flip ? phase + 32'h8000_0000 : phase;
      z = $signed({{32{folded[31]}}, folded});
      x = CORDIC_GAIN_Q30;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         angle = {32'd0, ATAN_TURNS[i % 32]};
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - angle;
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + angle;
         end
      end
      cosine = flip ? -x : x;
      sine = flip ? -y : y;
   endfunction

   // Round a Q45 sum to Q2.15 and saturate
   function automatic logic signed [SAMPLE_BITS:0] round_to_sample(input longint acc);
      longint r;
      r = (acc + ROUND_HALF) >>> 30;
      if (r > SAMPLE_MAX) r = SAMPLE_MAX;
      if (r < SAMPLE_MIN) r = SAMPLE_MIN;
      return r[SAMPLE_BITS:0];
   endfunction

   // Expected result of one pair; advances the pair and token counters
   function automatic rotated_pair_type predict_rotation(
                                                   input logic signed [SAMPLE_BITS-1:0] a,
                                                   input logic signed [SAMPLE_BITS-1:0] b);
      int unsigned      pairs, tokens;
      logic [31:0]      step;
      logic [63:0]      position, phase_product, next_product;
      longint           cosine, sine, av, bv;
      logic             last;
      rotated_pair_type r;
      pairs = (cfg_pairs == 0) ? 1 : cfg_pairs;
      if (pairs > MAX_PAIRS) pairs = MAX_PAIRS;
      tokens = (cfg_tokens == 0) ? 1 : cfg_tokens;
      step = (pair_index == 0) ? cfg_first_step : freq_step;
      position = {44'd0, cfg_start} + token_index;
      phase_product = position * {32'd0, step};
      cordic_sin_cos(phase_product[31:0], cosine, sine);
      if (cfg_inverse) sine = -sine;
      av = a;
      bv = b;
      r.rotated_first = round_to_sample(av * cosine - bv * sine);
      r.rotated_second = round_to_sample(av * sine + bv * cosine);
      last = (pair_index + 1 >= pairs);
      r.token_done = last;
      if (last) begin
         pair_index = 0;
         freq_step = cfg_first_step;
         token_index = (token_index + 1 >= tokens) ? 0 : token_index + 1;
      end else begin
         pair_index++;
         next_product = {32'd0, step} * {32'd0, cfg_step_ratio};
         freq_step = next_product[63:32];
      end
      return r;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 7))
         0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         default: return r[SAMPLE_BITS-1:0];
      endcase
   endfunction

   // Register write; idle cycle after it so back-to-back writes never collide
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         CSR_START_POSITION:     cfg_start = value[19:0];
         CSR_PAIRS_IN_USE:       cfg_pairs = value[6:0];
         CSR_TOKENS_IN_SEQUENCE: cfg_tokens = value[15:0];
         CSR_FIRST_STEP:         cfg_first_step = value;
         CSR_STEP_RATIO:         cfg_step_ratio = value;
         CSR_INVERSE_MODE:       cfg_inverse = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Offer one pair, with random idle cycles first; returns once accepted
   task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] a,
                            input logic signed [SAMPLE_BITS-1:0] b);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_first_value <= a;
      req_second_value <= b;
      do @(posedge clock); while (req_stall);
      expected_rotations.push_back(predict_rotation(a, b));
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (expected_rotations.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Random register set, biased toward the extremes; upper data bits are noise
   task automatic configure_random();
      logic [31:0] noise;
      noise = $urandom;
      case ($urandom_range(0, 3))
         0: csr_write(CSR_START_POSITION, {noise[31:20], 20'd0});
         1: csr_write(CSR_START_POSITION, {noise[31:20], 20'hF_FFFF});
         default: csr_write(CSR_START_POSITION, $urandom);
      endcase
      case ($urandom_range(0, 9))
         0: csr_write(CSR_PAIRS_IN_USE, {noise[31:7], 7'd0});
         1: csr_write(CSR_PAIRS_IN_USE, {noise[31:7], 7'd64});
         2: csr_write(CSR_PAIRS_IN_USE, {noise[31:7], 7'd127});
         3: csr_write(CSR_PAIRS_IN_USE, {noise[31:7], 7'd1});
         default: csr_write(CSR_PAIRS_IN_USE, {noise[31:7], 7'($urandom_range(1, 8))});
      endcase
      case ($urandom_range(0, 7))
         0: csr_write(CSR_TOKENS_IN_SEQUENCE, {noise[31:16], 16'd0});
         1: csr_write(CSR_TOKENS_IN_SEQUENCE, {noise[31:16], 16'hFFFF});
         2: csr_write(CSR_TOKENS_IN_SEQUENCE, {noise[31:16], 16'd1});
         default: csr_write(CSR_TOKENS_IN_SEQUENCE,
                            {noise[31:16], 16'($urandom_range(2, 6))});
      endcase
      case ($urandom_range(0, 4))
         0: csr_write(CSR_FIRST_STEP, 32'd0);
         1: csr_write(CSR_FIRST_STEP, 32'hFFFF_FFFF);
         2: csr_write(CSR_FIRST_STEP, FIRST_STEP_RESET);
         default: csr_write(CSR_FIRST_STEP, $urandom);
      endcase
      case ($urandom_range(0, 4))
         0: csr_write(CSR_STEP_RATIO, 32'd0);
         1: csr_write(CSR_STEP_RATIO, 32'hFFFF_FFFF);
         2: csr_write(CSR_STEP_RATIO, STEP_RATIO_RESET);
         default: csr_write(CSR_STEP_RATIO, $urandom);
      endcase
      csr_write(CSR_INVERSE_MODE, {noise[31:1], 1'($urandom_range(0, 1))});
   endtask

   // Sample extremes at the reset configuration (phase zero)
   task automatic test_sample_extremes();
      send_pair(16'sh7FFF, 16'sh7FFF);
      send_pair(-16'sh8000, -16'sh8000);
      send_pair(-16'sh8000, 16'sh7FFF);
      send_pair(16'sh0000, 16'sh0000);
      wait_until_drained();
   endtask

   // Phases at the quadrant edges, then the largest start position
   task automatic test_phase_quadrants();
      logic [31:0] phases [5];
      phases = '{32'h4000_0000, 32'h8000_0000, 32'hC000_0000, 32'h3FFF_FFFF, 32'hFFFF_FFFF};
      csr_write(CSR_PAIRS_IN_USE, 32'd1);
      csr_write(CSR_TOKENS_IN_SEQUENCE, 32'd1);
      csr_write(CSR_START_POSITION, 32'd1);
      foreach (phases[k]) begin
         csr_write(CSR_FIRST_STEP, phases[k]);
         send_pair(random_sample(), random_sample());
         wait_until_drained();
      end
      csr_write(CSR_START_POSITION, 32'h000F_FFFF);
      csr_write(CSR_FIRST_STEP, 32'd1);
      send_pair(16'sh7FFF, -16'sh8000);
      wait_until_drained();
   endtask

   task automatic test_inverse_mode();
      csr_write(CSR_INVERSE_MODE, 32'd1);
      csr_write(CSR_FIRST_STEP, 32'h1234_5678);
      send_pair(16'sh4000, 16'sh2000);
      send_pair(random_sample(), random_sample());
      wait_until_drained();
      csr_write(CSR_INVERSE_MODE, 32'd0);
   endtask

   // Zero pairs and tokens act as one, too many pairs clamp, unused index ignored
   task automatic test_count_limits();
      csr_write(CSR_PAIRS_IN_USE, 32'd0);
      csr_write(CSR_TOKENS_IN_SEQUENCE, 32'd0);
      csr_write(CSR_UNUSED_INDEX, 32'hFFFF_FFFF);
      send_pair(random_sample(), random_sample());
      wait_until_drained();
      csr_write(CSR_PAIRS_IN_USE, 32'd127);
      csr_write(CSR_STEP_RATIO, 32'hFFFF_FFFF);
      send_pair(random_sample(), random_sample());
      send_pair(random_sample(), random_sample());
      wait_until_drained();
   endtask

   // Limits lowered below the running counters end the pair or token at once
   task automatic test_shrink_mid_token();
      csr_write(CSR_PAIRS_IN_USE, 32'd1);
      csr_write(CSR_TOKENS_IN_SEQUENCE, 32'd1);
      send_pair(random_sample(), random_sample());
      wait_until_drained();
      csr_write(CSR_PAIRS_IN_USE, 32'd4);
      csr_write(CSR_TOKENS_IN_SEQUENCE, 32'd5);
      repeat (3) send_pair(random_sample(), random_sample());
      wait_until_drained();
      csr_write(CSR_PAIRS_IN_USE, 32'd2);
      send_pair(random_sample(), random_sample());
      wait_until_drained();
      csr_write(CSR_PAIRS_IN_USE, 32'd1);
      repeat (3) send_pair(random_sample(), random_sample());
      wait_until_drained();
      csr_write(CSR_TOKENS_IN_SEQUENCE, 32'd2);
      send_pair(random_sample(), random_sample());
      wait_until_drained();
   endtask

   // A new first step mid-token waits for the next pair zero
   task automatic test_first_step_change();
      csr_write(CSR_PAIRS_IN_USE, 32'd3);
      csr_write(CSR_TOKENS_IN_SEQUENCE, 32'd4);
      csr_write(CSR_START_POSITION, 32'd37);
      csr_write(CSR_STEP_RATIO, STEP_RATIO_RESET);
      send_pair(random_sample(), random_sample());
      wait_until_drained();
      csr_write(CSR_FIRST_STEP, 32'h0BAD_F00D);
      repeat (3) send_pair(random_sample(), random_sample());
      wait_until_drained();
   endtask

   // Receiver held off long enough for the block to back up onto its input
   task automatic test_output_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_requests <= hold_requests + 1;
      repeat (12) send_pair(random_sample(), random_sample());
      wait_until_drained();
   endtask

   task automatic run_traffic_phase(input int idle_pct, input int stall_pct,
                                    input int item_total);
      int sent, burst;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      sent = 0;
      while (sent < item_total) begin
         configure_random();
         burst = $urandom_range(10, 60);
         repeat (burst) send_pair(random_sample(), random_sample());
         sent += burst;
         wait_until_drained();
      end
   endtask

   task automatic test_streaming_traffic();
      run_traffic_phase(0, 0, 200);
      run_traffic_phase(72, 0, 200);
      run_traffic_phase(0, 72, 200);
      run_traffic_phase(27, 27, 200);
   endtask

   // Long receiver hold, one per request
   initial begin : receiver_hold
      int served;
      served = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != served) begin
            served = hold_requests;
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_on <= 1'b0;
         end
      end
   end

   // Compare each accepted result with the oldest expectation; drive rsp_stall
   initial begin : result_checker
      rotated_pair_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_rotations.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected result: first %0d second %0d done %0b",
                           rsp_rotated_first, rsp_rotated_second, rsp_token_done);
            end else begin
               want = expected_rotations.pop_front();
               if (rsp_rotated_first !== want.rotated_first ||
                   rsp_rotated_second !== want.rotated_second ||
                   rsp_token_done !== want.token_done) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("mismatch: expected first %0d second %0d done %0b, got %0d %0d %0b",
                              want.rotated_first, want.rotated_second, want.token_done,
                              rsp_rotated_first, rsp_rotated_second, rsp_token_done);
               end
            end
         end
         rsp_stall <= hold_on || ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   initial begin : watchdog
      #(64'd4_000_000);
      $display("rotary_position_embedding regression: fail");
      $finish;
   end

   initial begin : test_sequence
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_sample_extremes();
      test_phase_quadrants();
      test_inverse_mode();
      test_count_limits();
      test_shrink_mid_token();
      test_first_step_change();
      test_output_backpressure();
      test_streaming_traffic();
      wait_until_drained();
      receiver_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rotations.size() == 0)
         $display("rotary_position_embedding regression: pass");
      else
         $display("rotary_position_embedding regression: fail");
      $finish;
   end

endmodule
